// ===== hdl/pfr_pkg.sv =====
package pfr_pkg;

  // Window geometry
  localparam int MAX_PATTERN = 16;
  localparam int WIN_SLOTS   = 16;
  localparam int CNT_W       = $clog2(WIN_SLOTS);
  localparam int LEN_W       = $clog2(WIN_SLOTS + 1);
  localparam logic [LEN_W-1:0] LEN_LIM =
    LEN_W'((MAX_PATTERN < WIN_SLOTS) ? MAX_PATTERN : WIN_SLOTS);
  localparam logic [LEN_W-1:0] REPL_MAX = LEN_W'(WIN_SLOTS);

  // Character codes
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7a;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_NL      = 8'h0a;
  localparam logic [7:0] SET_LETTER_BASE = 8'd10;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_PAT_LO   = 3'd0,
    REG_PAT_HI   = 3'd1,
    REG_REPL_LO  = 3'd2,
    REG_REPL_HI  = 3'd3,
    REG_SCAN_SET = 3'd4,
    REG_SCAN_POS = 3'd5,
    REG_PAT_LEN  = 3'd6,
    REG_REPL_LEN = 3'd7
  } cfg_idx_e;

  typedef logic [WIN_SLOTS-1:0][7:0] win_t;

  typedef struct packed {
    win_t             pat;
    win_t             repl;
    logic [35:0]      scan_set;
    logic [4:0]       scan_pos;
    logic [4:0]       pat_len;
    logic [4:0]       repl_len;
  } cfg_t;

  // One burst of result bytes caused by an input transaction
  typedef struct packed {
    win_t             bytes;
    logic [LEN_W-1:0] cnt;
  } job_t;

  function automatic logic [7:0] fold_case(logic [7:0] c);
    if (c inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
      return c - CH_UPPER_A + CH_LOWER_A;
    end
    return c;
  endfunction

  // Membership test for the character-class position
  function automatic logic set_hit(logic [7:0] c, logic [35:0] set);
    logic [7:0] f;
    logic [7:0] off;
    f   = fold_case(c);
    off = '0;
    if (f inside {[CH_ZERO:CH_NINE]}) begin
      off = f - CH_ZERO;
      return set[off[5:0]];
    end else if (f inside {[CH_LOWER_A:CH_LOWER_Z]}) begin
      off = f - CH_LOWER_A + SET_LETTER_BASE;
      return set[off[5:0]];
    end
    return 1'b0;
  endfunction

endpackage

// ===== hdl/pfr_config.sv =====
module pfr_config (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [63:0]  cfg_wdata_i,
  output pfr_pkg::cfg_t cfg_o
);
  import pfr_pkg::*;

  logic [63:0] pat_lo_q, pat_hi_q, repl_lo_q, repl_hi_q;
  logic [35:0] scan_set_q;
  logic [4:0]  scan_pos_q, pat_len_q, repl_len_q;

  // Register file, written one register per transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q   <= '0;
      pat_hi_q   <= '0;
      repl_lo_q  <= '0;
      repl_hi_q  <= '0;
      scan_set_q <= '0;
      scan_pos_q <= 5'd16;
      pat_len_q  <= 5'd1;
      repl_len_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_PAT_LO:   pat_lo_q   <= cfg_wdata_i;
        REG_PAT_HI:   pat_hi_q   <= cfg_wdata_i;
        REG_REPL_LO:  repl_lo_q  <= cfg_wdata_i;
        REG_REPL_HI:  repl_hi_q  <= cfg_wdata_i;
        REG_SCAN_SET: scan_set_q <= cfg_wdata_i[35:0];
        REG_SCAN_POS: scan_pos_q <= cfg_wdata_i[4:0];
        REG_PAT_LEN:  pat_len_q  <= cfg_wdata_i[4:0];
        REG_REPL_LEN: repl_len_q <= cfg_wdata_i[4:0];
        default: ;
      endcase
    end
  end

  assign cfg_o.pat      = {pat_hi_q, pat_lo_q};
  assign cfg_o.repl     = {repl_hi_q, repl_lo_q};
  assign cfg_o.scan_set = scan_set_q;
  assign cfg_o.scan_pos = scan_pos_q;
  assign cfg_o.pat_len  = pat_len_q;
  assign cfg_o.repl_len = repl_len_q;

endmodule

// ===== hdl/pfr_match.sv =====
module pfr_match (
  input  pfr_pkg::cfg_t                cfg_i,
  input  pfr_pkg::win_t                win_i,
  input  logic [pfr_pkg::CNT_W-1:0]    cnt_i,
  input  logic [7:0]                   byte_i,
  input  logic                         end_i,
  output pfr_pkg::win_t                win_o,
  output logic [pfr_pkg::CNT_W-1:0]    cnt_o,
  output pfr_pkg::job_t                job_o
);
  import pfr_pkg::*;

  logic [LEN_W-1:0]     len;
  logic [CNT_W-1:0]     lm1;
  logic [CNT_W-1:0]     drop;
  logic [CNT_W-1:0]     kept;
  logic [LEN_W-1:0]     fill;
  logic [LEN_W-1:0]     rlen;
  win_t                 shifted;
  win_t                 merged;
  logic [WIN_SLOTS-1:0] ok;
  logic                 hit;

  // Effective lengths with saturation
  always_comb begin
    len = cfg_i.pat_len;
    if (len == '0) begin
      len = LEN_W'(1);
    end else if (len > LEN_LIM) begin
      len = LEN_LIM;
    end
    rlen = (cfg_i.repl_len > REPL_MAX) ? REPL_MAX : cfg_i.repl_len;
  end

  // Trim the oldest bytes so at most len-1 remain, then append the new byte
  always_comb begin
    lm1  = CNT_W'(len - LEN_W'(1));
    drop = (cnt_i > lm1) ? (cnt_i - lm1) : '0;
    kept = cnt_i - drop;
    fill = {1'b0, kept} + LEN_W'(1);
  end

  always_comb begin
    logic [LEN_W-1:0] src;
    src = '0;
    for (int i = 0; i < WIN_SLOTS; i++) begin
      src        = LEN_W'(i) + {1'b0, drop};
      shifted[i] = src[CNT_W] ? 8'h00 : win_i[src[CNT_W-1:0]];
      merged[i]  = (CNT_W'(i) < kept) ? shifted[i] : byte_i;
    end
  end

  // Parallel compare of every window position
  always_comb begin
    for (int i = 0; i < WIN_SLOTS; i++) begin
      if (LEN_W'(i) >= len) begin
        ok[i] = 1'b1;
      end else if (5'(i) == cfg_i.scan_pos) begin
        ok[i] = set_hit(merged[i], cfg_i.scan_set);
      end else begin
        ok[i] = (fold_case(merged[i]) == fold_case(cfg_i.pat[i]));
      end
    end
    hit = &ok;
  end

  // Next window state and result burst
  always_comb begin
    win_o     = merged;
    cnt_o     = fill[CNT_W-1:0];
    job_o.bytes = '0;
    job_o.cnt   = '0;
    if (end_i) begin
      // flush window, then the line terminator
      win_o = win_i;
      cnt_o = '0;
      for (int i = 0; i < WIN_SLOTS; i++) begin
        job_o.bytes[i] = (CNT_W'(i) < cnt_i) ? win_i[i] : CH_NL;
      end
      job_o.cnt = {1'b0, cnt_i} + LEN_W'(1);
    end else if (fill == len) begin
      if (hit) begin
        job_o.bytes = cfg_i.repl;
        job_o.cnt   = rlen;
        cnt_o       = '0;
      end else begin
        // pass the oldest byte and slide by one
        job_o.bytes[0] = merged[0];
        job_o.cnt      = LEN_W'(1);
        for (int i = 0; i < WIN_SLOTS - 1; i++) begin
          win_o[i] = merged[i+1];
        end
        cnt_o = lm1;
      end
    end
  end

endmodule

// ===== hdl/pfr_emit.sv =====
module pfr_emit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  pfr_pkg::job_t job_i,
  output logic          job_free_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_byte_o,
  output logic          out_last_o
);
  import pfr_pkg::*;

  win_t             buf_q;
  logic [LEN_W-1:0] rem_q;
  logic             out_valid_q;
  logic [7:0]       out_byte_q;
  logic             out_last_q;
  logic             out_load;

  assign out_load   = (rem_q != '0) && (!out_valid_q || out_ready_i);
  assign job_free_o = (rem_q == '0) || ((rem_q == LEN_W'(1)) && out_load);

  // Burst buffer, shifts down one byte per emitted result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else if (job_valid_i) begin
      rem_q <= job_i.cnt;
    end else if (out_load) begin
      rem_q <= rem_q - LEN_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_valid_i) begin
      buf_q <= job_i.bytes;
    end else if (out_load) begin
      for (int i = 0; i < WIN_SLOTS - 1; i++) begin
        buf_q[i] <= buf_q[i+1];
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_byte_q <= buf_q[0];
      out_last_q <= (rem_q == LEN_W'(1));
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== hdl/pattern_find_replace_stream.sv =====
// A result reaches the master side through the input register, burst buffer and output register.
// Throughput: one input transaction per cycle while m_axis_tready is high and each causes
// at most one result; one causing more holds the input as the burst buffer drains.
// Reset (rst_ni low, asynchronous): window empty, burst buffer and output register empty,
// registers at defaults (scan position none, pattern length one).
module pattern_find_replace_stream (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic        s_axis_tuser,   // [0] line_end
  // master side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,   // last_of_run
  // configuration
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i
);
  import pfr_pkg::*;

  cfg_t             cfg;
  logic             in_valid_q;
  logic [7:0]       in_byte_q;
  logic             in_end_q;
  win_t             win_q, win_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  job_t             job;
  logic             job_free;
  logic             consume;

  pfr_config u_config (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Input register
  assign consume       = in_valid_q && job_free;
  assign s_axis_tready = !in_valid_q || job_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_end_q  <= s_axis_tuser;
    end
  end

  pfr_match u_match (
    .cfg_i  (cfg),
    .win_i  (win_q),
    .cnt_i  (cnt_q),
    .byte_i (in_byte_q),
    .end_i  (in_end_q),
    .win_o  (win_d),
    .cnt_o  (cnt_d),
    .job_o  (job)
  );

  // Sliding window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (consume) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume) begin
      win_q <= win_d;
    end
  end

  pfr_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (consume && (job.cnt != '0)),
    .job_i       (job),
    .job_free_o  (job_free),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

// ===== hdl/pfr_checker.sv =====
module pfr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // Input is held off only while a burst is pending, so a result follows
  a_stall_has_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |=> m_axis_tvalid)
    else $error("input stalled without pending results");

  // Leaving reset: input open, no result shown
  a_reset_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> s_axis_tready && !m_axis_tvalid)
    else $error("bad state after reset");

endmodule

bind pattern_find_replace_stream pfr_checker u_pfr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
